[rtl/core/assert_macros.svh]
// Assertion helpers for the checker file (apdc_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define APDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define APDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[rtl/core/apdc_pkg.sv]
package apdc_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 15;
  localparam int LEN_W     = 12;
  localparam int SUM_W     = SAMPLE_W + 2;
  localparam int PROD_W    = 40;
  localparam int GAIN_FRAC = 15;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // word handed from one cell to the next
  typedef struct packed {
    logic    valid;
    sample_t sample;
  } link_t;

  typedef enum logic [2:0] {
    CELL_CLR,
    CELL_IDLE,
    CELL_Y,
    CELL_MUL,
    CELL_WR
  } cell_state_t;

  // register indexes
  localparam logic [2:0] REG_GAIN = 3'd0;
  localparam logic [2:0] REG_LEN0 = 3'd1;
  localparam int NUM_LEN_REGS = 4;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd16384;
  localparam int MIN_STAGE_LEN = 2;

  localparam logic [LEN_W-1:0] LEN_RESET [8] = '{
    12'd241, 12'd379, 12'd541, 12'd709, 12'd887, 12'd1061, 12'd1237, 12'd1423
  };

  localparam sample_t SAT_MAX = 24'sh7FFFFF;
  localparam sample_t SAT_MIN = -24'sh800000;
  localparam logic signed [PROD_W-1:0] PROD_ROUND = 40'sd16384;

  function automatic sample_t sat24(input logic signed [SUM_W-1:0] v);
    sample_t r;
    if (v > SUM_W'(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (v < SUM_W'(SAT_MIN)) begin
      r = SAT_MIN;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/apdc_regs.sv]
module apdc_regs #(
  parameter int STAGES = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [apdc_pkg::APB_AW-1:0]     paddr,
  input  logic [apdc_pkg::APB_DW-1:0]     pwdata,
  output logic [apdc_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  output logic [apdc_pkg::GAIN_W-1:0]     gain,
  output logic [apdc_pkg::LEN_W-1:0]      len [STAGES]
);

  logic [apdc_pkg::GAIN_W-1:0] gain_r;
  logic [apdc_pkg::LEN_W-1:0]  len_r [STAGES];
  logic [2:0]                  idx;
  logic                        wr;

  assign idx    = paddr[apdc_pkg::APB_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign gain   = gain_r;
  assign len    = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= apdc_pkg::GAIN_RESET;
      for (int k = 0; k < STAGES; k++) begin
        len_r[k] <= apdc_pkg::LEN_RESET[3'(k)];
      end
    end else if (wr) begin
      if (idx == apdc_pkg::REG_GAIN) begin
        gain_r <= pwdata[apdc_pkg::GAIN_W-1:0];
      end
      // only the first stages have a length register
      for (int k = 0; k < STAGES; k++) begin
        if (k < apdc_pkg::NUM_LEN_REGS && idx == apdc_pkg::REG_LEN0 + 3'(k)) begin
          len_r[k] <= pwdata[apdc_pkg::LEN_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == apdc_pkg::REG_GAIN) begin
      prdata = apdc_pkg::APB_DW'(gain_r);
    end
    for (int k = 0; k < STAGES; k++) begin
      if (k < apdc_pkg::NUM_LEN_REGS && idx == apdc_pkg::REG_LEN0 + 3'(k)) begin
        prdata = apdc_pkg::APB_DW'(len_r[k]);
      end
    end
  end

endmodule

[rtl/core/apdc_cell.sv]
module apdc_cell #(
  parameter int MAX_STAGE_LEN = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [apdc_pkg::GAIN_W-1:0] gain,
  input  logic [apdc_pkg::LEN_W-1:0]  len,
  input  apdc_pkg::link_t             up,
  output logic                        up_stall,
  output apdc_pkg::link_t             dn,
  input  logic                        dn_stall
);

  localparam int PW = $clog2(MAX_STAGE_LEN);
  localparam int LW = (PW + 1 > apdc_pkg::LEN_W) ? PW + 1 : apdc_pkg::LEN_W;
  localparam int PRW = apdc_pkg::PROD_W;
  localparam int SW = apdc_pkg::SUM_W;

  apdc_pkg::cell_state_t state_r, state_nxt;
  logic [PW-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  apdc_pkg::sample_t     x_r, x_nxt;
  apdc_pkg::sample_t     y_r, y_nxt;
  apdc_pkg::sample_t     o_r, o_nxt;
  logic                  ov_r, ov_nxt;
  logic signed [PRW-1:0] p_r, p_nxt;
  apdc_pkg::sample_t     rd_r;

  apdc_pkg::sample_t     mem [MAX_STAGE_LEN];
  logic                  we;
  logic [PW-1:0]         wa;
  apdc_pkg::sample_t     wd;

  apdc_pkg::sample_t     mul_a;
  logic signed [PRW-1:0] prod;
  logic signed [PRW-1:0] ps;
  logic signed [apdc_pkg::SAMPLE_W:0] m;
  logic signed [SW-1:0]  y_sum;
  logic signed [SW-1:0]  st_sum;
  logic [LW-1:0]         len_x;
  logic [LW-1:0]         eff_len;
  logic [LW-1:0]         pos_inc;

  // shared multiplier, rounded to nearest (ties up) by floor((p + 2^14) / 2^15)
  assign prod   = mul_a * $signed({1'b0, gain});
  assign ps     = p_r + apdc_pkg::PROD_ROUND;
  assign m      = $signed(ps[PRW-1:apdc_pkg::GAIN_FRAC]);
  assign y_sum  = SW'(rd_r) - SW'(m);
  assign st_sum = SW'(x_r) + SW'(m);

  assign len_x   = LW'(len);
  assign eff_len = (len_x < LW'(apdc_pkg::MIN_STAGE_LEN)) ? LW'(apdc_pkg::MIN_STAGE_LEN) :
                   (len_x > LW'(MAX_STAGE_LEN))           ? LW'(MAX_STAGE_LEN) : len_x;
  assign pos_inc = LW'(pos_r) + LW'(1);

  assign dn.valid  = ov_r;
  assign dn.sample = o_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= apdc_pkg::CELL_CLR;
      clr_cnt_r <= '0;
      pos_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pos_r     <= pos_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    o_r <= o_nxt;
    p_r <= p_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pos_nxt     = pos_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    o_nxt       = o_r;
    p_nxt       = p_r;
    ov_nxt      = ov_r && dn_stall;
    we          = 1'b0;
    wa          = pos_r;
    wd          = apdc_pkg::sat24(st_sum);
    mul_a       = y_r;
    up_stall    = 1'b1;
    unique case (state_r)
      apdc_pkg::CELL_CLR: begin
        we          = 1'b1;
        wa          = clr_cnt_r;
        wd          = '0;
        clr_cnt_nxt = clr_cnt_r + PW'(1);
        if (clr_cnt_r == PW'(MAX_STAGE_LEN - 1)) begin
          state_nxt = apdc_pkg::CELL_IDLE;
        end
      end
      apdc_pkg::CELL_IDLE: begin
        up_stall = 1'b0;
        mul_a    = up.sample;
        if (up.valid) begin
          x_nxt     = up.sample;
          p_nxt     = prod;
          state_nxt = apdc_pkg::CELL_Y;
        end
      end
      apdc_pkg::CELL_Y: begin
        // rd_r holds the tap read at the accept edge
        y_nxt     = apdc_pkg::sat24(y_sum);
        state_nxt = apdc_pkg::CELL_MUL;
      end
      apdc_pkg::CELL_MUL: begin
        p_nxt     = prod;
        state_nxt = apdc_pkg::CELL_WR;
      end
      apdc_pkg::CELL_WR: begin
        // hold here until the output slot frees up
        if (!ov_r || !dn_stall) begin
          we        = 1'b1;
          pos_nxt   = (pos_inc >= eff_len) ? '0 : PW'(pos_inc);
          o_nxt     = y_r;
          ov_nxt    = 1'b1;
          state_nxt = apdc_pkg::CELL_IDLE;
        end
      end
      default: begin
        state_nxt = apdc_pkg::CELL_CLR;
      end
    endcase
  end

endmodule

[rtl/core/allpass_diffuser_chain_top.sv]
// Four-stage Schroeder allpass diffuser (stage count set by STAGES).
// Input channel: in_valid / in_stall / in_sample, one signed Q1.23 sample per
// word. Output channel: out_valid / out_stall / out_sample, one diffused
// sample per input word, in order.
// Each stage is a cell with its own delay memory; a word passes through the
// cell's steps in order (tap read, d - g*x, g*y, write-back), and out_valid
// rises when the last cell has registered its write-back. Cells work on
// different words at once, but a cell takes no new word until it has written
// back the last one, as each cell has a single multiplier for both products.
// Reset: the APB registers return to their defaults (gain 0.5, lengths
// 241/379/541/709) and every cell zeroes all MAX_STAGE_LEN entries (2048 at
// the default) of its memory, one entry per cycle. in_stall stays high until
// that pass is done; register writes are taken throughout.
// When out_stall is high the last result is held; words back up cell by
// cell and in_stall rises once the first cell cannot hand its word on.
// Registers: 0 gain (unsigned Q0.15), 1..4 stage lengths, at byte address 4*index.
// Program them only while the chain is empty.
module allpass_diffuser_chain_top #(
  parameter int STAGES        = 4,
  parameter int MAX_STAGE_LEN = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [23:0]               in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [23:0]               out_sample,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [apdc_pkg::APB_AW-1:0]      paddr,
  input  logic [apdc_pkg::APB_DW-1:0]      pwdata,
  output logic [apdc_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  logic [apdc_pkg::GAIN_W-1:0] gain;
  logic [apdc_pkg::LEN_W-1:0]  len [STAGES];
  apdc_pkg::link_t             link  [STAGES+1];
  logic                        stall [STAGES+1];

  apdc_regs #(
    .STAGES (STAGES)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gain    (gain),
    .len     (len)
  );

  assign link[0].valid  = in_valid;
  assign link[0].sample = in_sample;
  assign in_stall       = stall[0];
  assign out_valid      = link[STAGES].valid;
  assign out_sample     = link[STAGES].sample;
  assign stall[STAGES]  = out_stall;

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    apdc_cell #(
      .MAX_STAGE_LEN (MAX_STAGE_LEN)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .gain     (gain),
      .len      (len[k]),
      .up       (link[k]),
      .up_stall (stall[k]),
      .dn       (link[k+1]),
      .dn_stall (stall[k+1])
    );
  end

endmodule

[rtl/core/apdc_checker.sv]
`include "assert_macros.svh"

module apdc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] out_sample
);

  // a held result keeps its value
  `APDC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_sample), "out word changed while stalled")

  // the first cell stalls its input after taking a word
  `APDC_ASSERT(a_in_busy, clk, rst_n, in_valid && !in_stall |=> in_stall, "input taken on consecutive cycles")

  // reset empties the chain and starts the memory clear
  `APDC_ASSERT_ALWAYS(a_rst_state, clk, !rst_n |=> in_stall && !out_valid, "chain not empty after reset")

endmodule

bind allpass_diffuser_chain_top apdc_checker u_apdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_sample (out_sample)
);

[tb/tb.sv]
module tb;

  localparam int NSTAGE      = 4;
  localparam int DEPTH       = 2048;
  localparam int QUIET_LIMIT = 6000;
  localparam int RAND_ITEMS  = 700;
  localparam apdc_pkg::sample_t SMAX = 24'sh7FFFFF;
  localparam apdc_pkg::sample_t SMIN = -24'sh800000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  apdc_pkg::sample_t             in_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  apdc_pkg::sample_t             out_sample;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [apdc_pkg::APB_AW-1:0]   paddr = '0;
  logic [apdc_pkg::APB_DW-1:0]   pwdata = '0;
  logic [apdc_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  allpass_diffuser_chain_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  apdc_pkg::sample_t           ring [NSTAGE][DEPTH];
  int unsigned                 wpos [NSTAGE];
  logic [apdc_pkg::GAIN_W-1:0] gain_q15 = 15'd16384;
  logic [apdc_pkg::LEN_W-1:0]  len_reg [NSTAGE] = '{12'd241, 12'd379, 12'd541, 12'd709};

  apdc_pkg::sample_t sample_q [$];
  apdc_pkg::sample_t diffused_q [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          in_fire = 1'b0;
  bit          gaps_on = 1'b1;

  // round to nearest, ties up: floor((v*g + 2^14) / 2^15)
  function automatic longint scale_by_gain(longint v);
    longint p;
    p = v * longint'(gain_q15) + 64'sd16384;
    return p >>> apdc_pkg::GAIN_FRAC;
  endfunction

  function automatic apdc_pkg::sample_t clip24(longint v);
    if (v > longint'(SMAX)) return SMAX;
    if (v < longint'(SMIN)) return SMIN;
    return apdc_pkg::sample_t'(v);
  endfunction

  function automatic apdc_pkg::sample_t diffuse(apdc_pkg::sample_t x_in);
    apdc_pkg::sample_t x, d, y;
    int unsigned       len, p;
    x = x_in;
    for (int k = 0; k < NSTAGE; k++) begin
      len = len_reg[k];
      if (len < 2) len = 2;
      if (len > DEPTH) len = DEPTH;
      p = wpos[k];
      if (p >= DEPTH) p = 0;
      d = ring[k][p];
      y = clip24(longint'(d) - scale_by_gain(longint'(x)));
      ring[k][p] = clip24(longint'(x) + scale_by_gain(longint'(y)));
      p++;
      // a position left beyond a shortened length wraps here
      if (p >= len) p = 0;
      wpos[k] = p;
      x = y;
    end
    return x;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 12);
    return $urandom_range(20, 120);
  endfunction

  function automatic apdc_pkg::sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0: return SMAX;
      1: return SMIN;
      2: return '0;
      3, 4: return apdc_pkg::sample_t'($urandom_range(0, 511)) - 24'sd256;
      default: return apdc_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [apdc_pkg::LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0: return apdc_pkg::LEN_W'($urandom_range(0, 1));
      1: return apdc_pkg::LEN_W'(DEPTH);
      2: return apdc_pkg::LEN_W'($urandom_range(DEPTH + 1, 4095));
      3: return apdc_pkg::LEN_W'($urandom_range(41, DEPTH - 1));
      default: return apdc_pkg::LEN_W'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic logic [apdc_pkg::GAIN_W-1:0] pick_gain();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return 15'd32767;
      2: return 15'd16384;
      default: return apdc_pkg::GAIN_W'($urandom_range(0, 32767));
    endcase
  endfunction

  // input side
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // stalled: hold the word
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (sample_q.size() != 0) begin
      in_valid  <= 1'b1;
      in_sample <= sample_q.pop_front();
      send_gap  <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 99) < 25) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 100)
                                                 : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    apdc_pkg::sample_t want;
    in_fire = rst_n && in_valid && (in_stall === 1'b0);
    if (in_fire) begin
      diffused_q.push_back(diffuse(in_sample));
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (diffused_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none got %0d", $time, out_sample);
      end else begin
        want = diffused_q.pop_front();
        if (out_sample !== want) begin
          mismatches++;
          $display("%0t: out_sample expected %0d got %0d", $time, want, out_sample);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(input int idx, input logic [apdc_pkg::APB_DW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= apdc_pkg::APB_AW'(idx * 4);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == int'(apdc_pkg::REG_GAIN)) begin
      gain_q15 = val[apdc_pkg::GAIN_W-1:0];
    end else begin
      len_reg[idx - int'(apdc_pkg::REG_LEN0)] = val[apdc_pkg::LEN_W-1:0];
    end
  endtask

  task automatic set_lens(input int l0, input int l1, input int l2, input int l3);
    reg_write(int'(apdc_pkg::REG_LEN0),     apdc_pkg::APB_DW'(l0));
    reg_write(int'(apdc_pkg::REG_LEN0) + 1, apdc_pkg::APB_DW'(l1));
    reg_write(int'(apdc_pkg::REG_LEN0) + 2, apdc_pkg::APB_DW'(l2));
    reg_write(int'(apdc_pkg::REG_LEN0) + 3, apdc_pkg::APB_DW'(l3));
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || diffused_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned sent, n, per;
    bit          square;
    for (int k = 0; k < NSTAGE; k++) begin
      wpos[k] = 0;
      for (int i = 0; i < DEPTH; i++) ring[k][i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, field extremes
    sample_q = '{SMAX, SMIN, 24'sd0, -24'sd1, 24'sd1, 24'sh555555};
    drain();

    // max gain, shortest delays: saturation in the feedback
    reg_write(int'(apdc_pkg::REG_GAIN), apdc_pkg::APB_DW'(32767));
    set_lens(2, 2, 2, 2);
    sample_q = '{SMAX, SMAX, SMIN, SMIN, SMAX, SMIN};
    drain();

    // zero gain; lengths below two and above the maximum
    reg_write(int'(apdc_pkg::REG_GAIN), apdc_pkg::APB_DW'(0));
    set_lens(0, 1, 4095, 3);
    sample_q = '{24'shAAAAAA, -24'sd1, SMAX, 24'sd1};
    drain();

    // shrink lengths under the current write positions
    reg_write(int'(apdc_pkg::REG_GAIN), apdc_pkg::APB_DW'(20000));
    set_lens(10, 12, 14, 16);
    sample_q = '{SMIN, 24'sd12345, SMAX, -24'sd777, 24'sh3C3C3C};
    drain();
    set_lens(3, 2, 4, 2);
    sample_q = '{SMAX, -24'sd4000000, 24'sd99};
    drain();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 1)) begin
        reg_write(int'(apdc_pkg::REG_GAIN), apdc_pkg::APB_DW'(pick_gain()));
      end
      for (int k = 0; k < NSTAGE; k++) begin
        if ($urandom_range(0, 1)) begin
          reg_write(int'(apdc_pkg::REG_LEN0) + k, apdc_pkg::APB_DW'(pick_len()));
        end
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      square  = ($urandom_range(0, 3) == 0);
      per     = $urandom_range(1, 8);
      n       = $urandom_range(10, 60);
      for (int i = 0; i < n; i++) begin
        if (square) sample_q.push_back(((i / per) % 2) ? SMAX : SMIN);
        else sample_q.push_back(pick_sample());
      end
      sent += n;
      drain();
    end

    gaps_on = 1'b1;
    repeat (40) @(posedge clk);
    if (mismatches == 0 && diffused_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/apdc_pkg.sv
rtl/core/apdc_regs.sv
rtl/core/apdc_cell.sv
rtl/core/allpass_diffuser_chain_top.sv
rtl/core/apdc_checker.sv
tb/tb.sv
